// File: rtl/framed_command_receiver_defines.svh
// Assertion helpers shared by the receiver's modules.
// They expect clk and rst_n to be visible in the module that uses them.
`ifndef FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/frc_pkg.sv
package frc_pkg;

  localparam logic [7:0] START_MARK  = 8'hA5;
  localparam logic [7:0] END_MARK    = 8'h0D;
  localparam int         OVERHEAD    = 6;
  localparam int         PAYLOAD_AT  = 7;
  localparam int         CAPTURE_LEN = 12;
  localparam logic [6:0] CFG_RESET   = 7'd50;

  localparam logic [7:0] CODE_SPEED = 8'd6;
  localparam logic [7:0] CODE_TRACK = 8'd9;

  localparam logic [2:0] ST_INCOMPLETE = 3'd0;
  localparam logic [2:0] ST_GOOD       = 3'd1;
  localparam logic [2:0] ST_SUM_ERR    = 3'd2;
  localparam logic [2:0] ST_END_ERR    = 3'd3;
  localparam logic [2:0] ST_LEN_ERR    = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } frc_beat_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic        [7:0]  cmd_code;
    logic signed [31:0] speed_left;
    logic signed [31:0] speed_right;
    logic        [15:0] angle_first;
    logic        [15:0] angle_second;
    logic        [15:0] pos_x;
    logic        [15:0] pos_y;
    logic        [15:0] target_x;
    logic        [15:0] target_y;
  } frc_result_t;

endpackage

// File: rtl/frc_if.sv
interface frc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface frc_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic        [7:0]  cmd_code;
  logic signed [31:0] speed_left;
  logic signed [31:0] speed_right;
  logic        [15:0] angle_first;
  logic        [15:0] angle_second;
  logic        [15:0] pos_x;
  logic        [15:0] pos_y;
  logic        [15:0] target_x;
  logic        [15:0] target_y;

  modport source (
    output valid, input ready,
    output status, output cmd_code, output speed_left, output speed_right,
    output angle_first, output angle_second, output pos_x, output pos_y,
    output target_x, output target_y
  );
  modport sink (
    input valid, output ready,
    input status, input cmd_code, input speed_left, input speed_right,
    input angle_first, input angle_second, input pos_x, input pos_y,
    input target_x, input target_y
  );
endinterface

// File: rtl/frc_in_stage.sv
module frc_in_stage
  import frc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  frc_in_if.sink    in_bus,
  input  logic      take,
  output frc_beat_t beat
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       accept;

  assign in_bus.ready = !valid_r || take;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_bus.rx_byte;
    end
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;

endmodule

// File: rtl/frc_parser.sv
`include "framed_command_receiver_defines.svh"

module frc_parser
  import frc_pkg::*;
#(
  parameter int FRAME_LIMIT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [6:0] max_len,
  input  frc_beat_t  beat,
  output logic       take,
  frc_out_if.source  out_bus
);

  localparam int         PW      = $clog2(FRAME_LIMIT + 1);
  localparam logic [7:0] LIMIT_C = 8'(FRAME_LIMIT);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    sum_lo_r, sum_lo_nxt;
  logic [7:0]    sum_hi_r, sum_hi_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [7:0]    cap_r   [CAPTURE_LEN];
  logic [7:0]    cap_nxt [CAPTURE_LEN];
  logic          out_valid_r, out_valid_nxt;
  frc_result_t   res_r, res_nxt;

  logic [7:0]    limit;
  logic [8:0]    len_lo;
  logic [PW:0]   pos_x;
  logic [PW:0]   len_x;
  logic [3:0]    cap_idx;
  logic [7:0]    b;

  assign take = beat.valid && (!out_valid_r || out_bus.ready);
  assign b    = beat.data;

  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    code_nxt   = code_r;
    cap_nxt    = cap_r;
    res_nxt    = '0;
    limit      = ({1'b0, max_len} > LIMIT_C) ? LIMIT_C : {1'b0, max_len};
    len_lo     = {1'b0, sum_lo_r} + 9'(OVERHEAD);
    pos_x      = {1'b0, pos_r};
    len_x      = {1'b0, len_r};
    cap_idx    = 4'(pos_r - PW'(PAYLOAD_AT));

    priority if (pos_r == '0) begin
      if (b == START_MARK) begin
        pos_nxt    = PW'(1);
        sum_nxt    = '0;
        sum_lo_nxt = '0;
        sum_hi_nxt = '0;
        code_nxt   = '0;
        for (int i = 0; i < CAPTURE_LEN; i++) begin
          cap_nxt[i] = '0;
        end
      end
    end else if (pos_r == PW'(1)) begin
      // The low length byte waits in the checksum low register.
      sum_lo_nxt = b;
      pos_nxt    = PW'(2);
    end else if (pos_r == PW'(2)) begin
      sum_lo_nxt = '0;
      if (b != '0 || len_lo > {1'b0, limit}) begin
        pos_nxt        = '0;
        res_nxt.status = ST_LEN_ERR;
      end else begin
        len_nxt = len_lo[PW-1:0];
        pos_nxt = PW'(3);
      end
    end else begin
      if (pos_r == PW'(3)) begin
        code_nxt = b;
      end
      if (pos_r >= PW'(PAYLOAD_AT) && pos_r < PW'(PAYLOAD_AT + CAPTURE_LEN)) begin
        cap_nxt[cap_idx] = b;
      end
      if (pos_x + (PW+1)'(4) <= len_x) begin
        sum_nxt = sum_r + 16'(b);
      end
      if (pos_x + (PW+1)'(3) == len_x) begin
        sum_lo_nxt = b;
      end
      if (pos_x + (PW+1)'(2) == len_x) begin
        sum_hi_nxt = b;
      end

      if (pos_x + (PW+1)'(1) < len_x) begin
        pos_nxt = pos_r + PW'(1);
      end else begin
        pos_nxt          = '0;
        res_nxt.cmd_code = code_r;
        priority if (sum_r != {sum_hi_r, sum_lo_r}) begin
          res_nxt.status = ST_SUM_ERR;
        end else if (b != END_MARK) begin
          res_nxt.status = ST_END_ERR;
        end else begin
          res_nxt.status = ST_GOOD;
          if (code_r == CODE_SPEED) begin
            res_nxt.speed_left  = $signed({cap_nxt[3], cap_nxt[2], cap_nxt[1], cap_nxt[0]});
            res_nxt.speed_right = $signed({cap_nxt[7], cap_nxt[6], cap_nxt[5], cap_nxt[4]});
          end else if (code_r == CODE_TRACK) begin
            res_nxt.angle_first  = {cap_nxt[1], cap_nxt[0]};
            res_nxt.angle_second = {cap_nxt[3], cap_nxt[2]};
            res_nxt.pos_x        = {cap_nxt[5], cap_nxt[4]};
            res_nxt.pos_y        = {cap_nxt[7], cap_nxt[6]};
            res_nxt.target_x     = {cap_nxt[9], cap_nxt[8]};
            res_nxt.target_y     = {cap_nxt[11], cap_nxt[10]};
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      len_r    <= len_nxt;
      sum_r    <= sum_nxt;
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
      code_r   <= code_nxt;
      cap_r    <= cap_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = res_r.status;
  assign out_bus.cmd_code     = res_r.cmd_code;
  assign out_bus.speed_left   = res_r.speed_left;
  assign out_bus.speed_right  = res_r.speed_right;
  assign out_bus.angle_first  = res_r.angle_first;
  assign out_bus.angle_second = res_r.angle_second;
  assign out_bus.pos_x        = res_r.pos_x;
  assign out_bus.pos_y        = res_r.pos_y;
  assign out_bus.target_x     = res_r.target_x;
  assign out_bus.target_y     = res_r.target_y;

  // A beat that ends a frame or rejects its length sends the parser back to hunting.
  `FRC_ASSERT_NEXT(a_hunt_after_finish, take && pos_r != '0 && res_nxt.status != ST_INCOMPLETE, pos_r == '0, "parser did not return to hunting after a finished frame")
  // Decoded speeds appear only on a good frame that carries the speed code.
  `FRC_ASSERT_SAME(a_speed_only_good, out_valid_r && res_r.speed_left != '0, res_r.status == ST_GOOD && res_r.cmd_code == CODE_SPEED, "speed field set outside a good speed frame")
  // Inside a frame the position stays below an accepted frame length.
  `FRC_ASSERT_SAME(a_pos_in_frame, pos_r >= PW'(3), len_r >= PW'(OVERHEAD) && pos_r < len_r, "byte position outside the current frame")

endmodule

// File: rtl/framed_command_receiver.sv
// Channel    Dir   Payload                                   Handshake
// in_bus     in    rx_byte                                   valid/ready
// out_bus    out   status, cmd_code, speeds, angles, points  valid/ready
// cfg        in    cfg_wdata (max_frame_len)                 cfg_we, no wait
//
// Every accepted byte yields exactly one result beat: the byte is first held in the
// input register, and the result register is loaded when the parser takes it.
// One byte per cycle is sustained; the input register and the result register
// each hold one beat, so the input stalls only while both are full and the result
// beat is not taken.
// Reset is synchronous and active low and leaves the parser hunting for a start byte.
// The configuration register resets to a frame limit of 50 bytes.
module framed_command_receiver
  import frc_pkg::*;
#(
  parameter int FRAME_LIMIT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  frc_in_if.sink     in_bus,
  frc_out_if.source  out_bus,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  logic [6:0] max_len_r;
  logic [6:0] max_len_nxt;
  logic       take;
  frc_beat_t  beat;

  assign max_len_nxt = cfg_we ? cfg_wdata : max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= CFG_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  frc_in_stage u_in_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .take   (take),
    .beat   (beat)
  );

  frc_parser #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .max_len (max_len_r),
    .beat    (beat),
    .take    (take),
    .out_bus (out_bus)
  );

endmodule
